### src/fmod_pkg.sv
// fmod_pkg: types and constants shared by the binary64 remainder block.
// No dependencies.
package fmod_pkg;
  localparam int unsigned ExpW  = 11;
  localparam int unsigned FracW = 52;
  localparam int unsigned SigW  = 53;
  localparam logic [63:0] QNaN  = 64'h7FF8_0000_0000_0000;
  localparam logic [ExpW-1:0] ExpMax = 11'h7FF;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_NORM,
    CMD_REDUCE,
    CMD_FINAL,
    CMD_RENORM,
    CMD_PACK
  } cmd_e;

  typedef struct packed {
    logic special;   // result already settled by classification
    logic norm_done; // both significands normalized
    logic red_done;  // exponent difference used up
    logic zero_hit;  // a step reached exactly zero
    logic ren_done;  // remainder renormalized
  } fmod_status_t;
endpackage

### src/fmod_datapath.sv
// fmod_datapath: operand registers, shift-subtract reducer, repacker.
// Depends on fmod_pkg.
module fmod_datapath (
  input  logic                  clk_i,
  input  fmod_pkg::cmd_e        cmd_i,
  input  logic [63:0]           dividend_i,
  input  logic [63:0]           divisor_i,
  output fmod_pkg::fmod_status_t status_o,
  output logic [63:0]           result_o
);
  import fmod_pkg::*;

  logic [63:0] res_q, res_d;
  logic [SigW:0] mx_q, mx_d;
  logic [SigW-1:0] my_q, my_d;
  logic signed [12:0] ex_q, ex_d, ey_q, ey_d;
  logic sign_q, sign_d, special_q, special_d, zero_q, zero_d;

  logic [10:0] exa, eya;
  logic [63:0] xa, ya;
  logic ynan;
  logic [SigW+1:0] diff;
  logic [12:0] sh;

  always_comb begin
    exa  = dividend_i[62:52];
    eya  = divisor_i[62:52];
    xa   = {dividend_i[62:0], 1'b0};
    ya   = {divisor_i[62:0], 1'b0};
    ynan = (eya == ExpMax) && (divisor_i[51:0] != '0);
    diff = {1'b0, mx_q} - {2'b0, my_q};
    sh   = 13'(1) - ex_q;
    res_d = res_q; mx_d = mx_q; my_d = my_q; ex_d = ex_q; ey_d = ey_q;
    sign_d = sign_q; special_d = special_q; zero_d = zero_q;
    case (cmd_i)
      CMD_LOAD: begin
        sign_d = dividend_i[63];
        zero_d = 1'b0;
        special_d = 1'b1;
        ex_d = 13'(exa);
        ey_d = 13'(eya);
        mx_d = (exa == '0) ? {2'b00, dividend_i[51:0]} : {2'b01, dividend_i[51:0]};
        my_d = (eya == '0) ? {1'b0, divisor_i[51:0]} : {1'b1, divisor_i[51:0]};
        if (ya == '0 || ynan || exa == ExpMax) res_d = QNaN;
        else if (xa == ya) res_d = {dividend_i[63], 63'd0};
        else if (xa < ya) res_d = dividend_i;
        else begin
          special_d = 1'b0;
          if (exa == '0) ex_d = 13'sd1;
          if (eya == '0) ey_d = 13'sd1;
        end
      end
      CMD_NORM: begin
        if (!mx_q[SigW-1]) begin mx_d = {mx_q[SigW-1:0], 1'b0}; ex_d = ex_q - 13'sd1; end
        if (!my_q[SigW-1]) begin my_d = {my_q[SigW-2:0], 1'b0}; ey_d = ey_q - 13'sd1; end
      end
      CMD_REDUCE: begin
        // mx < 2*my, so the difference stays below my and the shift fits
        if (!diff[SigW+1]) begin
          if (diff == '0) zero_d = 1'b1;
          mx_d = {diff[SigW-1:0], 1'b0};
        end else mx_d = {mx_q[SigW-1:0], 1'b0};
        ex_d = ex_q - 13'sd1;
      end
      CMD_FINAL: begin
        if (!diff[SigW+1]) begin
          if (diff == '0) zero_d = 1'b1;
          mx_d = diff[SigW:0];
        end
      end
      CMD_RENORM: begin
        if (!mx_q[SigW-1] && mx_q != '0) begin
          mx_d = {mx_q[SigW-1:0], 1'b0}; ex_d = ex_q - 13'sd1;
        end
      end
      CMD_PACK: begin
        if (zero_q) res_d = {sign_q, 63'd0};
        else if (ex_q > 13'sd0) res_d = {sign_q, ex_q[10:0], mx_q[FracW-1:0]};
        else if (sh < 13'd64) res_d = {sign_q, 63'(64'(mx_q) >> sh[5:0])};
        else res_d = {sign_q, 63'd0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d; mx_q <= mx_d; my_q <= my_d; ex_q <= ex_d; ey_q <= ey_d;
    sign_q <= sign_d; special_q <= special_d; zero_q <= zero_d;
  end

  assign status_o.special   = special_q;
  assign status_o.norm_done = mx_q[SigW-1] && my_q[SigW-1];
  assign status_o.red_done  = !(ex_q > ey_q);
  assign status_o.zero_hit  = zero_q;
  assign status_o.ren_done  = mx_q[SigW-1] || (mx_q == '0);
  assign result_o = res_q;
endmodule

### src/fmod_ctrl.sv
// fmod_ctrl: sequencer for load, normalize, reduce, renormalize, pack.
// Depends on fmod_pkg.
module fmod_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  fmod_pkg::fmod_status_t status_i,
  output fmod_pkg::cmd_e         cmd_o
);
  import fmod_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CLASS, S_NORM, S_RED, S_FIN, S_REN, S_PACK, S_OUT
  } state_e;
  state_e state_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    case (state_q)
      S_IDLE:  cmd_o = (in_valid_i) ? CMD_LOAD : CMD_NONE;
      S_NORM:  cmd_o = CMD_NORM;
      S_RED:   cmd_o = (status_i.red_done || status_i.zero_hit) ? CMD_NONE : CMD_REDUCE;
      S_FIN:   cmd_o = CMD_FINAL;
      S_REN:   cmd_o = CMD_RENORM;
      S_PACK:  cmd_o = CMD_PACK;
      default: cmd_o = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_CLASS;
        S_CLASS: state_q <= status_i.special ? S_OUT : S_NORM;
        S_NORM:  if (status_i.norm_done) state_q <= S_RED;
        S_RED: begin
          if (status_i.zero_hit) state_q <= S_PACK;
          else if (status_i.red_done) state_q <= S_FIN;
        end
        S_FIN:   state_q <= status_i.zero_hit ? S_PACK : S_REN;
        S_REN:   if (status_i.ren_done || status_i.zero_hit) state_q <= S_PACK;
        S_PACK:  state_q <= S_OUT;
        S_OUT:   if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o) else $error("accept while busy");
  a_pack_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PACK |=> out_valid_o) else $error("pack not followed by output");
endmodule

### src/float64_remainder.sv
// float64_remainder: IEEE-754 binary64 fmod(x, y), sign of x.
// Depends on fmod_pkg, fmod_ctrl, fmod_datapath.
//   channel | signals                          | dir
//   in      | in_valid_i, in_stall_o, dividend_i, divisor_i | sink
//   out     | out_valid_o, out_stall_i, remainder_o        | source
// One item at a time. Special operands go from classify straight to output;
// otherwise: normalize shifts (up to 52), exponent difference (up to ~2100,
// one shift-subtract per cycle), final subtract, renormalize shifts (up to 52).
// Input stalls from accept until the cycle after the result is taken.
// Reset is asynchronous, active low; a result holds while out_stall_i is high.
module float64_remainder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] remainder_o
);
  import fmod_pkg::*;

  cmd_e         cmd;
  fmod_status_t status;

  fmod_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .status_i(status), .cmd_o(cmd)
  );

  fmod_datapath u_dp (
    .clk_i, .cmd_i(cmd), .dividend_i, .divisor_i,
    .status_o(status), .result_o(remainder_o)
  );
endmodule

### tb/tb_float64_remainder.sv
// tb_float64_remainder: self-checking testbench for the binary64 fmod block.
// Drives operand pairs with random gaps and output stalls, predicts each remainder
// with an integer model of fmod, and compares in order. Depends on float64_remainder.
module tb_float64_remainder;
  import fmod_pkg::*;

  class fmod_scoreboard;
    logic [63:0] pending_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function logic [63:0] unpack_sig(logic [63:0] bits, ref int e);
      logic [63:0] probe;
      int sh;
      if (e != 0) return (bits & {12'h0, {52{1'b1}}}) | (64'd1 << FracW);
      probe = bits << 12;
      while (probe[63] == 1'b0 && probe != 0) begin
        e--;
        probe = probe << 1;
      end
      sh = 1 - e;
      return (sh < 64) ? (bits << sh) : 64'd0;
    endfunction

    static function logic [63:0] fmod_bits(logic [63:0] xb, logic [63:0] yb);
      int ex, ey, sh;
      logic [63:0] sgn, xa, ya, mx, my, d;
      logic y_nan;
      ex = int'(xb[62:52]);
      ey = int'(yb[62:52]);
      sgn = {xb[63], 63'd0};
      xa = xb << 1;
      ya = yb << 1;
      y_nan = (yb[62:52] == ExpMax) && (yb[51:0] != 0);
      if (ya == 0 || y_nan || xb[62:52] == ExpMax) return QNaN;
      if (xa <= ya) return (xa == ya) ? sgn : xb;
      mx = unpack_sig(xb, ex);
      my = unpack_sig(yb, ey);
      for (; ex > ey; ex--) begin
        d = mx - my;
        if (!d[63]) begin
          if (d == 0) return sgn;
          mx = d;
        end
        mx = mx << 1;
      end
      d = mx - my;
      if (!d[63]) begin
        if (d == 0) return sgn;
        mx = d;
      end
      while ((mx >> FracW) == 0 && mx != 0) begin
        mx = mx << 1;
        ex--;
      end
      if (ex > 0) begin
        mx = mx - (64'd1 << FracW);
        mx = mx | (64'(ex) << FracW);
      end else begin
        sh = 1 - ex;
        mx = (sh < 64) ? (mx >> sh) : 64'd0;
      end
      return mx | sgn;
    endfunction

    function void note_operands(logic [63:0] x, logic [63:0] y);
      pending_q.push_back(fmod_bits(x, y));
    endfunction

    function void check_remainder(logic [63:0] got);
      logic [63:0] want;
      if (pending_q.size() == 0) begin
        $error("unexpected remainder %h", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        $error("remainder: expected %h actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [63:0] dividend_i, divisor_i, remainder_o;

  float64_remainder dut (.*);

  fmod_scoreboard sb = new();
  int idle_cycles;
  bit hold_long;
  logic [63:0] dir_x[$], dir_y[$];

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) sb.note_operands(dividend_i, divisor_i);
    if (out_valid_o && !out_stall_i) sb.check_remainder(remainder_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 40000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly finite, nearby exponents; sometimes a zero exponent; sometimes anything
  function automatic logic [63:0] rand_double(int base_exp);
    logic [63:0] v;
    int e;
    v = rand64();
    case ($urandom_range(0, 9))
      0, 1: ;
      2: v[62:52] = 11'(0);
      default: begin
        e = base_exp + $urandom_range(0, 80) - 40;
        if (e < 0) e = 0;
        if (e > 2046) e = 2046;
        v[62:52] = 11'(e);
      end
    endcase
    return v;
  endfunction

  task automatic send(logic [63:0] x, logic [63:0] y);
    int gap;
    gap = $urandom_range(0, 12);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    dividend_i <= x;
    divisor_i <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int n;
    logic [63:0] x, y;
    out_stall_i = 1'b0;
    in_valid_i = 1'b0;
    dividend_i = '0;
    divisor_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    dir_x = '{64'h4014_0000_0000_0000, 64'h4014_0000_0000_0000, 64'hC014_0000_0000_0000,
              64'h7FF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'h4000_0000_0000_0000,
              64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000,
              64'hBFF0_0000_0000_0000, 64'h4010_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
              64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF,
              64'h3FF8_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0003,
              64'h4340_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF};
    dir_y = '{64'h4008_0000_0000_0000, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
              64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h7FF8_0000_0000_0000,
              64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
              64'hBFF0_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h0000_0000_0000_0001,
              64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0003, 64'h0000_0000_0000_0007,
              64'h3FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h0010_0000_0000_0002,
              64'h3FF0_0000_0000_0001, 64'h0010_0000_0000_0001};
    foreach (dir_x[i]) send(dir_x[i], dir_y[i]);
    stop_sending();
    drain();

    hold_long = 1'b1;
    for (n = 0; n < 6; n++) send(rand_double(1023), rand_double(1023));
    stop_sending();
    hold_long = 1'b0;
    drain();

    for (n = 0; n < 244; n++) begin
      x = rand_double(1023 + $urandom_range(0, 1) * ($urandom_range(0, 2046) - 1023));
      y = ($urandom_range(0, 5) == 0) ? rand64() : rand_double(int'(x[62:52]) - 30);
      if ($urandom_range(0, 3) == 0) {x, y} = {y, x};
      send(x, y);
    end
    stop_sending();
    drain();
    repeat (4500) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls, with long hold-offs while hold_long is set
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(negedge clk_i);
        out_stall_i <= 1'b0;
        @(negedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        w = $urandom_range(1, 12);
        out_stall_i <= 1'b1;
        repeat (w) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(0, 20)) @(negedge clk_i);
      end
    end
  end
endmodule

### filelist.f
src/fmod_pkg.sv
src/fmod_datapath.sv
src/fmod_ctrl.sv
src/float64_remainder.sv
tb/tb_float64_remainder.sv
